// ----- src/kti_pkg.sv -----
`default_nettype none
package kti_pkg;
	localparam int MAX_KEYS   = 64;
	localparam int CHANNELS   = 8;
	localparam int KEY_W      = 6;
	localparam int CH_W       = 3;
	localparam int CNT_W      = 7;
	localparam int VADDR_W    = KEY_W + CH_W;
	localparam int FRAC_LIMIT = 8;
	localparam int QUOT_W     = 20;
	localparam int DIV_STEPS  = 48;

	typedef enum logic [1:0] {
		CMD_WR_KEY = 2'd0,
		CMD_WR_VAL = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_RD_VAL = 2'd3
	} cmd_t;
endpackage
`default_nettype wire

// ----- src/kti_ram.sv -----
`default_nettype none
module kti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- src/kti_div.sv -----
`default_nettype none
module kti_div
	import kti_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [31:0]       num,
	input  wire logic [31:0]       den,
	output logic                   done,
	output logic [QUOT_W-1:0]      quot
);
	localparam int STEP_W = $clog2(DIV_STEPS + 1);

	logic [STEP_W-1:0] cnt_q;
	logic [47:0]       dvd_q;
	logic [31:0]       rem_q;
	logic [31:0]       den_q;
	logic [QUOT_W-1:0] quot_q;
	logic              done_q;
	logic [32:0]       trial;
	logic              fits;

	assign trial = {rem_q, dvd_q[47]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= STEP_W'(DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= {num, 16'd0};
			rem_q  <= '0;
			den_q  <= den;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q  <= {dvd_q[46:0], 1'b0};
			rem_q  <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

// ----- src/keyframe_track_interpolator_top.sv -----
// queries scan the stored keys in turn and may then use the 48-step divider and three multiplies
// to blend between the two selected keys
// throughput: one request at a time; the time and value memories are each read once per cycle
// reset: async active low; after reset a pass over all 512 value-memory entries clears the
// presence bits while no request is taken
`default_nettype none
module keyframe_track_interpolator_top
	import kti_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [6:0]  cfg_wr_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,  // command, key_index, channel, time_req, value
	input  wire logic        s_tuser,  // ease
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // result_value
	output logic [1:0]       m_tuser   // valid_res, saturated
);
	typedef enum logic [19:0] {
		ST_IDLE  = 20'h00001, ST_CLR   = 20'h00002, ST_SRD   = 20'h00004,
		ST_SCMP  = 20'h00008, ST_SEL   = 20'h00010, ST_SVRD  = 20'h00020,
		ST_SVCAP = 20'h00040, ST_PTA   = 20'h00080, ST_PTB   = 20'h00100,
		ST_PVA   = 20'h00200, ST_PVB   = 20'h00400, ST_PCHK  = 20'h00800,
		ST_DIV   = 20'h01000, ST_FRAC  = 20'h02000, ST_MUL1  = 20'h04000,
		ST_MUL2  = 20'h08000, ST_POLY  = 20'h10000, ST_MUL3  = 20'h20000,
		ST_FIN   = 20'h40000, ST_RESP  = 20'h80000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] key_count_q, n;
	logic [VADDR_W-1:0] clr_q;

	cmd_t in_cmd;
	logic [KEY_W-1:0] in_key;
	logic [CH_W-1:0]  in_ch;
	logic [31:0]      in_time, in_val;
	logic             acc;

	logic [31:0] t_q;
	logic [CH_W-1:0] ch_q;
	logic [CNT_W-1:0] i_q;
	logic [KEY_W-1:0] g1_q, g2_q, ka_q, kb_q;
	logic has_g1_q, has_g2_q;
	logic [31:0] ta_q, tb_q, va_q;
	logic ea_q, eb_q, pa_q, neg_q;
	logic [QUOT_W-1:0] fm_q;
	logic signed [20:0] f_q;
	logic signed [41:0] f2_q;
	logic signed [62:0] f3_q;
	logic signed [31:0] st_q;
	logic signed [64:0] prod_q;
	logic [31:0] res_q;
	logic ok_q, sat_q;
	logic m_valid_q;
	logic [31:0] m_data_q;
	logic [1:0] m_user_q;

	logic t_we, v_we;
	logic [KEY_W-1:0] t_addr;
	logic [VADDR_W-1:0] v_addr;
	logic [32:0] t_wdata, t_rdata, v_wdata, v_rdata;

	logic [32:0] num, den;
	logic [31:0] an, ad;
	logic ovr, div_start, div_done;
	logic [QUOT_W-1:0] quot;
	logic signed [63:0] pf, pf2, pf3, poly;
	logic signed [32:0] dv;
	logic signed [49:0] r;

	assign in_cmd  = cmd_t'(s_tdata[1:0]);
	assign in_key  = s_tdata[7:2];
	assign in_ch   = s_tdata[10:8];
	assign in_time = s_tdata[42:11];
	assign in_val  = s_tdata[74:43];
	assign s_tready = state_q == ST_IDLE;
	assign acc = s_tvalid && s_tready;
	assign n = (key_count_q > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : key_count_q;

	// memory ports
	always_comb begin
		t_we    = acc && in_cmd == CMD_WR_KEY;
		t_wdata = {s_tuser, in_time};
		case (state_q)
			ST_SRD:  t_addr = i_q[KEY_W-1:0];
			ST_PTA:  t_addr = ka_q;
			ST_PTB:  t_addr = kb_q;
			default: t_addr = in_key;
		endcase
		v_we    = (state_q == ST_CLR) || (acc && in_cmd == CMD_WR_VAL);
		v_wdata = (state_q == ST_CLR) ? '0 : {1'b1, in_val};
		case (state_q)
			ST_CLR:  v_addr = clr_q;
			ST_SVRD: v_addr = {ka_q, ch_q};
			ST_PVA:  v_addr = {ka_q, ch_q};
			ST_PVB:  v_addr = {kb_q, ch_q};
			default: v_addr = {in_key, in_ch};
		endcase
	end

	kti_ram #(.WIDTH(33), .DEPTH(MAX_KEYS)) u_time_ram (
		.clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata)
	);

	kti_ram #(.WIDTH(33), .DEPTH(MAX_KEYS * CHANNELS)) u_val_ram (
		.clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
	);

	// fraction setup
	always_comb begin
		num = {1'b0, t_q} - {1'b0, ta_q};
		den = {1'b0, tb_q} - {1'b0, ta_q};
		an  = num[32] ? 32'(-num) : num[31:0];
		ad  = den[32] ? 32'(-den) : den[31:0];
		ovr = {3'b000, an} > {ad, 3'b000};
		div_start = state_q == ST_PCHK && v_rdata[32] && pa_q && ta_q != tb_q && !ovr;
	end

	kti_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(an), .den(ad),
		.done(div_done), .quot(quot)
	);

	// ease polynomial and final scale
	always_comb begin
		pf   = 64'(f_q) <<< 32;
		pf2  = 64'(f2_q) <<< 16;
		pf3  = 64'(f3_q);
		case ({ea_q, eb_q})
			2'b11:   poly = (pf2 <<< 1) + pf2 - (pf3 <<< 1);
			2'b10:   poly = (pf2 <<< 1) - pf3;
			2'b01:   poly = pf2 + pf - pf3;
			default: poly = pf;
		endcase
		dv = 33'(signed'(tb_q)) - 33'(signed'(va_q));
		r  = 50'(signed'(va_q)) + 50'(signed'(prod_q[64:16]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			key_count_q <= '0;
			clr_q       <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				key_count_q <= cfg_wr_data;
			end
			if (state_q == ST_RESP && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						case (in_cmd)
							CMD_QUERY:  state_q <= (n == '0) ? ST_RESP : ST_SRD;
							CMD_RD_VAL: state_q <= ({1'b0, in_key} < n) ? ST_SVCAP : ST_RESP;
							default:    state_q <= ST_RESP;
						endcase
					end
				end
				ST_SRD:  state_q <= ST_SCMP;
				ST_SCMP: begin
					if (t_q > t_rdata[31:0] && i_q + 1'b1 != n) begin
						state_q <= ST_SRD;
					end else begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (!has_g2_q) begin
						state_q <= (g1_q == '0) ? ST_SVRD : ST_PTA;
					end else if (!has_g1_q) begin
						state_q <= ({1'b0, g2_q} + 1'b1 == n) ? ST_SVRD : ST_PTA;
					end else begin
						state_q <= ST_PTA;
					end
				end
				ST_SVRD:  state_q <= ST_SVCAP;
				ST_SVCAP: state_q <= ST_RESP;
				ST_PTA:   state_q <= ST_PTB;
				ST_PTB:   state_q <= ST_PVA;
				ST_PVA:   state_q <= ST_PVB;
				ST_PVB:   state_q <= ST_PCHK;
				ST_PCHK: begin
					if (!v_rdata[32] || !pa_q || ta_q == tb_q) begin
						state_q <= ST_RESP;
					end else if (ovr) begin
						state_q <= ST_FRAC;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FRAC;
					end
				end
				ST_FRAC: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_POLY;
				ST_POLY: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_FIN;
				ST_FIN:  state_q <= ST_RESP;
				ST_RESP: begin
					if (!m_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				t_q      <= in_time;
				ch_q     <= in_ch;
				i_q      <= '0;
				has_g1_q <= 1'b0;
				has_g2_q <= 1'b0;
				res_q    <= '0;
				sat_q    <= 1'b0;
				ok_q     <= in_cmd == CMD_WR_KEY || in_cmd == CMD_WR_VAL;
			end
			ST_SCMP: begin
				if (t_q > t_rdata[31:0]) begin
					g1_q     <= i_q[KEY_W-1:0];
					has_g1_q <= 1'b1;
					i_q      <= i_q + 1'b1;
				end else if (t_q < t_rdata[31:0]) begin
					g2_q     <= i_q[KEY_W-1:0];
					has_g2_q <= 1'b1;
				end else begin
					g1_q     <= i_q[KEY_W-1:0];
					g2_q     <= i_q[KEY_W-1:0];
					has_g1_q <= 1'b1;
					has_g2_q <= 1'b1;
				end
			end
			ST_SEL: begin
				if (!has_g2_q) begin
					ka_q <= (g1_q == '0) ? g1_q : g1_q - 1'b1;
					kb_q <= g1_q;
				end else if (!has_g1_q) begin
					ka_q <= g2_q;
					kb_q <= g2_q + 1'b1;
				end else begin
					ka_q <= g1_q;
					kb_q <= g2_q;
				end
			end
			ST_SVCAP: begin
				ok_q  <= v_rdata[32];
				res_q <= v_rdata[32] ? v_rdata[31:0] : '0;
			end
			ST_PTB: begin
				ta_q <= t_rdata[31:0];
				ea_q <= t_rdata[32];
			end
			ST_PVA: begin
				tb_q <= t_rdata[31:0];
				eb_q <= t_rdata[32];
			end
			ST_PVB: begin
				va_q <= v_rdata[31:0];
				pa_q <= v_rdata[32];
			end
			ST_PCHK: begin
				neg_q <= num[32] ^ den[32];
				fm_q  <= QUOT_W'(FRAC_LIMIT) << 16;
				sat_q <= ovr && v_rdata[32] && pa_q && ta_q != tb_q;
				ok_q  <= v_rdata[32] && pa_q;
				res_q <= (v_rdata[32] && pa_q && ta_q == tb_q) ? va_q : '0;
				// tb_q now holds vb for the scale step
				tb_q  <= v_rdata[31:0];
			end
			ST_DIV: begin
				if (div_done) begin
					fm_q <= quot;
				end
			end
			ST_FRAC: f_q  <= neg_q ? -signed'({1'b0, fm_q}) : signed'({1'b0, fm_q});
			ST_MUL1: f2_q <= f_q * f_q;
			ST_MUL2: f3_q <= f2_q * f_q;
			ST_POLY: st_q <= poly[63:32];
			ST_MUL3: prod_q <= st_q * dv;
			ST_FIN: begin
				if (r > 50'sd2147483647) begin
					res_q <= 32'h7fffffff;
					sat_q <= 1'b1;
				end else if (r < -50'sd2147483648) begin
					res_q <= 32'h80000000;
					sat_q <= 1'b1;
				end else begin
					res_q <= r[31:0];
				end
			end
			ST_RESP: begin
				if (!m_valid_q || m_tready) begin
					m_data_q <= res_q;
					m_user_q <= {sat_q, ok_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
endmodule
`default_nettype wire

// ----- src/kti_checker.sv -----
`default_nettype none
module kti_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	a_sat_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[1] && !m_tuser[0]))
		else $error("saturated on invalid result");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tdata == 32'd0)
		else $error("invalid result not zero");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request taken while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");
endmodule

bind keyframe_track_interpolator_top kti_checker u_kti_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none
module tb_top;
	import kti_pkg::*;

	typedef struct {
		cmd_t        cmd;
		logic [5:0]  key;
		logic [2:0]  ch;
		logic [31:0] t;
		logic [31:0] v;
		logic        ease;
	} req_t;

	typedef struct {
		logic [31:0] value;
		logic        found;
		logic        sat;
	} result_t;

	typedef struct {
		bit      is_cfg;
		logic [6:0] cfg;
		req_t    req;
		bit      typed;
		result_t res;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_wr_en = 0;
	logic [6:0]  cfg_wr_data = '0;
	logic        s_tvalid = 0;
	wire         s_tready;
	logic [79:0] s_tdata = '0;  // command, key_index, channel, time_req, value
	logic        s_tuser = 0;   // ease
	wire         m_tvalid;
	logic        m_tready = 0;
	wire  [31:0] m_tdata;       // result_value
	wire  [1:0]  m_tuser;       // valid_res, saturated

	keyframe_track_interpolator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	logic [31:0] key_time [MAX_KEYS];
	logic        key_ease [MAX_KEYS];
	logic [31:0] chan_val [MAX_KEYS*CHANNELS];
	logic        chan_present [MAX_KEYS*CHANNELS];
	logic [6:0]  key_count_reg;
	logic [31:0] time_plan [MAX_KEYS];

	result_t pending_results [$];
	int      errors = 0;
	bit      calm = 0;
	int      rx_stall = 0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	function automatic bit fetch_value(int k, int ch, output logic [31:0] v);
		v = '0;
		if (!chan_present[k*CHANNELS + ch])
			return 0;
		v = chan_val[k*CHANNELS + ch];
		return 1;
	endfunction

	function automatic bit blend_pair(int a, int b, logic [31:0] t, int ch,
			output logic [31:0] res, inout logic sat);
		logic [31:0] va, vb;
		longint num, den, f, f2, f3, poly, st, r;
		longint unsigned an, ad, fm;
		bit neg;
		res = '0;
		if (!fetch_value(a, ch, va) || !fetch_value(b, ch, vb))
			return 0;
		if (key_time[a] == key_time[b]) begin
			res = va;
			return 1;
		end
		num = longint'({32'd0, t}) - longint'({32'd0, key_time[a]});
		den = longint'({32'd0, key_time[b]}) - longint'({32'd0, key_time[a]});
		neg = (num < 0) != (den < 0);
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		if (an > 64'(FRAC_LIMIT) * ad) begin
			fm = 64'(FRAC_LIMIT) << 16;
			sat = 1;
		end else begin
			fm = (an << 16) / ad;
		end
		f = neg ? -longint'(fm) : longint'(fm);
		f2 = f * f;
		f3 = f2 * f;
		if (key_ease[a] && key_ease[b])
			poly = -2 * f3 + 3 * f2 * 65536;
		else if (key_ease[a])
			poly = -f3 + 2 * f2 * 65536;
		else if (key_ease[b])
			poly = -f3 + f2 * 65536 + f * 64'sd4294967296;
		else
			poly = f * 64'sd4294967296;
		st = poly >>> 32;
		r = longint'(signed'(va)) + ((st * (longint'(signed'(vb)) - longint'(signed'(va)))) >>> 16);
		if (r > 64'sd2147483647) begin
			r = 64'sd2147483647;
			sat = 1;
		end else if (r < -64'sd2147483648) begin
			r = -64'sd2147483648;
			sat = 1;
		end
		res = r[31:0];
		return 1;
	endfunction

	function automatic result_t apply_request(req_t q);
		result_t o;
		int n, g1, g2;
		bit ok;
		logic [31:0] v;
		logic sat;
		n = (key_count_reg > MAX_KEYS) ? MAX_KEYS : key_count_reg;
		ok = 0;
		sat = 0;
		v = '0;
		g1 = -1;
		g2 = -1;
		case (q.cmd)
			CMD_WR_KEY: begin
				key_time[q.key] = q.t;
				key_ease[q.key] = q.ease;
				ok = 1;
			end
			CMD_WR_VAL: begin
				chan_val[q.key*CHANNELS + q.ch] = q.v;
				chan_present[q.key*CHANNELS + q.ch] = 1;
				ok = 1;
			end
			CMD_QUERY: begin
				for (int i = 0; i < n; i++) begin
					if (q.t > key_time[i]) begin
						g1 = i;
					end else if (q.t < key_time[i]) begin
						g2 = i;
						break;
					end else begin
						g1 = i;
						g2 = i;
						break;
					end
				end
				if (g1 < 0 && g2 < 0)
					ok = 0;
				else if (g2 < 0)
					ok = (g1 == 0) ? fetch_value(0, q.ch, v)
						: blend_pair(g1 - 1, g1, q.t, q.ch, v, sat);
				else if (g1 < 0)
					ok = (g2 + 1 == n) ? fetch_value(g2, q.ch, v)
						: blend_pair(g2, g2 + 1, q.t, q.ch, v, sat);
				else
					ok = blend_pair(g1, g2, q.t, q.ch, v, sat);
			end
			default: begin
				if (q.key < n)
					ok = fetch_value(q.key, q.ch, v);
			end
		endcase
		if (!ok || q.cmd == CMD_WR_KEY || q.cmd == CMD_WR_VAL) begin
			v = '0;
			sat = 0;
		end
		o.value = v;
		o.found = ok;
		o.sat = sat;
		return o;
	endfunction

	task automatic send_request(req_t q, bit typed, result_t typed_res);
		int gap;
		result_t pred;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {5'd0, q.v, q.t, q.ch, q.key, q.cmd};
		s_tuser = q.ease;
		s_tvalid = 1;
		do @(posedge clk); while (!s_tready);
		pred = apply_request(q);
		pending_results.insert(pending_results.size(), typed ? typed_res : pred);
	endtask

	task automatic drain_and_config(logic [6:0] n);
		@(negedge clk);
		s_tvalid = 0;
		wait (pending_results.size() == 0);
		repeat (250) @(negedge clk);
		cfg_wr_en = 1;
		cfg_wr_data = n;
		key_count_reg = n;
		@(negedge clk);
		cfg_wr_en = 0;
	endtask

	function automatic req_t mk(cmd_t c, int k, int ch, logic [31:0] t, logic [31:0] v, int e);
		req_t q;
		q.cmd = c;
		q.key = 6'(k);
		q.ch = 3'(ch);
		q.t = t;
		q.v = v;
		q.ease = 1'(e);
		return q;
	endfunction

	function automatic row_t row(req_t q, bit typed, logic [31:0] val, bit found);
		row_t r;
		r.is_cfg = 0;
		r.cfg = '0;
		r.req = q;
		r.typed = typed;
		r.res.value = val;
		r.res.found = found;
		r.res.sat = 0;
		return r;
	endfunction

	function automatic row_t cfg_row(logic [6:0] n);
		row_t r;
		r = row(mk(CMD_RD_VAL, 0, 0, 0, 0, 0), 0, 0, 0);
		r.is_cfg = 1;
		r.cfg = n;
		return r;
	endfunction

	always @(negedge clk) begin
		if (rx_stall > 0) begin
			m_tready = 0;
			rx_stall--;
		end else begin
			m_tready = 1;
			rx_stall = pick_gap();
		end
	end

	always @(posedge clk) begin
		result_t e;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result value=%h user=%b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (m_tdata !== e.value) begin
					$display("%0t: result_value expected %h actual %h", $time, e.value, m_tdata);
					errors++;
				end
				if (m_tuser[0] !== e.found) begin
					$display("%0t: valid_res expected %b actual %b", $time, e.found, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== e.sat) begin
					$display("%0t: saturated expected %b actual %b", $time, e.sat, m_tuser[1]);
					errors++;
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		row_t rows [$];
		logic [6:0] counts [9];
		int n, j, r, base, step;
		req_t q;
		result_t none;
		none.value = '0;
		none.found = 0;
		none.sat = 0;
		key_count_reg = '0;
		for (int i = 0; i < MAX_KEYS*CHANNELS; i++)
			chan_present[i] = 0;
		for (int i = 0; i < MAX_KEYS; i++)
			time_plan[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// empty table and read past the key count, then key and value writes and queries over four keys
		rows.insert(rows.size(), row(mk(CMD_QUERY, 0, 0, 5, 0, 0), 1, 0, 0));
		rows.insert(rows.size(), row(mk(CMD_RD_VAL, 0, 0, 0, 0, 0), 1, 0, 0));
		rows.insert(rows.size(), row(mk(CMD_WR_KEY, 0, 0, 100, 0, 0), 1, 0, 1));
		rows.insert(rows.size(), row(mk(CMD_WR_KEY, 1, 0, 200, 0, 1), 1, 0, 1));
		rows.insert(rows.size(), row(mk(CMD_WR_KEY, 2, 0, 200, 0, 0), 1, 0, 1));
		rows.insert(rows.size(), row(mk(CMD_WR_KEY, 3, 0, 32'hFFFFFFFF, 0, 1), 1, 0, 1));
		rows.insert(rows.size(), row(mk(CMD_WR_VAL, 0, 0, 0, 32'h7FFFFFFF, 0), 1, 0, 1));
		rows.insert(rows.size(), row(mk(CMD_WR_VAL, 1, 0, 0, 32'h80000000, 0), 1, 0, 1));
		rows.insert(rows.size(), row(mk(CMD_WR_VAL, 2, 0, 0, 0, 0), 1, 0, 1));
		rows.insert(rows.size(), row(mk(CMD_WR_VAL, 3, 0, 0, 32'h00010000, 0), 1, 0, 1));
		rows.insert(rows.size(),
			row(mk(CMD_WR_VAL, 63, 7, 32'hFFFFFFFF, 32'hFFFFFFFB, 1), 1, 0, 1));
		rows.insert(rows.size(), cfg_row(4));
		rows.insert(rows.size(), row(mk(CMD_QUERY, 0, 0, 0, 0, 0), 0, 0, 0));
		rows.insert(rows.size(), row(mk(CMD_QUERY, 0, 0, 100, 0, 0), 1, 32'h7FFFFFFF, 1));
		rows.insert(rows.size(), row(mk(CMD_QUERY, 0, 0, 150, 0, 0), 0, 0, 0));
		rows.insert(rows.size(), row(mk(CMD_QUERY, 0, 0, 200, 0, 0), 1, 32'h80000000, 1));
		rows.insert(rows.size(),
			row(mk(CMD_QUERY, 0, 0, 32'hFFFFFFFF, 0, 0), 1, 32'h00010000, 1));
		rows.insert(rows.size(), row(mk(CMD_QUERY, 0, 0, 1000, 0, 0), 0, 0, 0));
		// channel never written
		rows.insert(rows.size(), row(mk(CMD_QUERY, 0, 5, 150, 0, 0), 1, 0, 0));
		rows.insert(rows.size(), row(mk(CMD_RD_VAL, 63, 7, 0, 0, 0), 1, 0, 0));
		rows.insert(rows.size(), row(mk(CMD_RD_VAL, 0, 0, 0, 0, 0), 1, 32'h7FFFFFFF, 1));
		// lone key gives a step on both sides
		rows.insert(rows.size(), cfg_row(1));
		rows.insert(rows.size(), row(mk(CMD_QUERY, 0, 0, 50, 0, 0), 1, 32'h7FFFFFFF, 1));
		rows.insert(rows.size(), row(mk(CMD_QUERY, 0, 0, 5000, 0, 0), 1, 32'h7FFFFFFF, 1));
		// oversized key count
		rows.insert(rows.size(), cfg_row(127));
		rows.insert(rows.size(), row(mk(CMD_RD_VAL, 63, 7, 0, 0, 0), 1, 32'hFFFFFFFB, 1));

		foreach (rows[i]) begin
			if (rows[i].is_cfg)
				drain_and_config(rows[i].cfg);
			else
				send_request(rows[i].req, rows[i].typed, rows[i].res);
		end

		counts = '{7'd2, 7'd64, 7'd127, 7'd3, 7'd1, 7'd0, 7'd16, 7'd5, 7'd64};
		foreach (counts[p]) begin
			n = (counts[p] > MAX_KEYS) ? MAX_KEYS : counts[p];
			calm = (p % 3 == 2);
			drain_and_config(p == 7 ? 7'($urandom_range(0, 127)) : counts[p]);
			n = (key_count_reg > MAX_KEYS) ? MAX_KEYS : key_count_reg;
			base = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 5000);
			case ($urandom_range(0, 3))
				0: step = $urandom_range(0, 2);
				1: step = $urandom_range(1, 100);
				2: step = $urandom_range(1000, 60000000);
				default: step = 0;
			endcase
			for (int k = 0; k < MAX_KEYS; k++) begin
				time_plan[k] = (step == 0 && k > 0) ? 32'($urandom) : 32'(base + k * step);
				if (step == 0 && k > 0 && $urandom_range(0, 3) != 0)
					time_plan[k] = time_plan[k-1] + $urandom_range(0, 1 << $urandom_range(0, 31));
			end
			for (int k = 0; k < MAX_KEYS; k++)
				send_request(mk(CMD_WR_KEY, k, $urandom, time_plan[k], $urandom, $urandom),
					0, none);
			for (int it = 0; it < 100; it++) begin
				r = $urandom_range(0, 99);
				j = (n > 0) ? $urandom_range(0, n - 1) : 0;
				q = mk(CMD_RD_VAL, $urandom, $urandom, $urandom, $urandom, $urandom);
				if (r < 8) begin
					q.cmd = CMD_WR_KEY;
					if ($urandom_range(0, 4) != 0)
						q.t = time_plan[q.key];
				end else if (r < 38) begin
					q.cmd = CMD_WR_VAL;
					if ($urandom_range(0, 1) == 0)
						q.key = 6'(j);
					if ($urandom_range(0, 2) == 0)
						q.v = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
					else if ($urandom_range(0, 1) == 0)
						q.v = 32'($signed($urandom_range(0, 400000)) - 200000);
				end else if (r < 85) begin
					q.cmd = CMD_QUERY;
					case ($urandom_range(0, 5))
						0: q.t = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
						1: ;
						2: q.t = time_plan[j];
						default: q.t = time_plan[j] + 32'($signed($urandom_range(0, 200)) - 100);
					endcase
					if ($urandom_range(0, 3) != 0)
						q.ch = 3'($urandom_range(0, 1));
				end else begin
					if ($urandom_range(0, 2) != 0)
						q.key = 6'(j);
				end
				send_request(q, 0, none);
			end
		end

		@(negedge clk);
		s_tvalid = 0;
		wait (pending_results.size() == 0);
		repeat (250) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
